// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table: entry layout, operation and
// status codes, result word and sequencer states.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int SKT_CAPACITY = 128;

	localparam int KEY_W     = 32;
	localparam int AMOUNT_W  = 16;
	localparam int PRICE_W   = 24;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 7;
	localparam int COUNT_W   = 8;
	localparam int TOT_AMT_W = 23;
	localparam int TOT_VAL_W = 47;

	localparam logic [TOT_AMT_W-1:0] TOT_AMT_MAX = '1;
	localparam logic [TOT_VAL_W-1:0] TOT_VAL_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STATS  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [AMOUNT_W-1:0] amount;
		logic [KEY_W-1:0]    key;
	} entry_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		entry_t            ent;
	} op_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic [TOT_VAL_W-1:0] total_value;
		logic [TOT_AMT_W-1:0] total_amount;
		logic [COUNT_W-1:0]   entry_count;
		logic [PRICE_W-1:0]   found_price;
		logic [AMOUNT_W-1:0]  found_amount;
		logic [POS_W-1:0]     position;
		logic [STATUS_W-1:0]  status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_STATS,
		S_DONE
	} state_t;

endpackage

// ===== rtl/skt_mem.sv =====
// ----------------------------------------------------------------------------
// skt_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_mem
	import skt_pkg::*;
#(
	parameter int CAPACITY = SKT_CAPACITY,
	localparam int ADDR_W = $clog2(CAPACITY)
) (
	input  logic              clk,
	input  logic              ren,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata
);

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/skt_mac.sv =====
// ----------------------------------------------------------------------------
// skt_mac
// Statistics unit: registered quantity times price, then accumulation of the
// quantity and value sums, saturated to the result field widths.
// ----------------------------------------------------------------------------
module skt_mac
	import skt_pkg::*;
#(
	parameter int CAPACITY = SKT_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 valid,
	input  logic [AMOUNT_W-1:0]  amount,
	input  logic [PRICE_W-1:0]   price,
	output logic                 busy,
	output logic [TOT_AMT_W-1:0] tot_amount,
	output logic [TOT_VAL_W-1:0] tot_value
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int PROD_W = AMOUNT_W + PRICE_W;
	localparam int ACC_A_W = (AMOUNT_W + CNT_W > TOT_AMT_W) ? AMOUNT_W + CNT_W : TOT_AMT_W + 1;
	localparam int ACC_V_W = (PROD_W + CNT_W > TOT_VAL_W) ? PROD_W + CNT_W : TOT_VAL_W + 1;

	logic                v_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [AMOUNT_W-1:0] amt_s2;
	logic [ACC_A_W-1:0]  acc_a_q;
	logic [ACC_V_W-1:0]  acc_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(amount) * PROD_W'(price);
		amt_s2  <= amount;
		if (clear) begin
			acc_a_q <= '0;
			acc_v_q <= '0;
		end else if (v_s2) begin
			acc_a_q <= acc_a_q + ACC_A_W'(amt_s2);
			acc_v_q <= acc_v_q + ACC_V_W'(prod_s2);
		end
	end

	assign busy = v_s2;

	always_comb begin
		tot_amount = (acc_a_q > ACC_A_W'(TOT_AMT_MAX)) ? TOT_AMT_MAX : acc_a_q[TOT_AMT_W-1:0];
		tot_value  = (acc_v_q > ACC_V_W'(TOT_VAL_MAX)) ? TOT_VAL_MAX : acc_v_q[TOT_VAL_W-1:0];
	end

endmodule

// ===== rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl
// Operation sequencer: ordered key scan, shift up for insert, shift down for
// delete and a statistics walk, all through the single entry memory.
// ----------------------------------------------------------------------------
module skt_ctrl
	import skt_pkg::*;
#(
	parameter int CAPACITY = SKT_CAPACITY,
	localparam int ADDR_W = $clog2(CAPACITY)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  op_t                  in_op,
	output logic                 res_valid,
	input  logic                 res_take,
	output result_t              res,
	output logic                 mem_ren,
	output logic [ADDR_W-1:0]    mem_raddr,
	input  entry_t               mem_rdata,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_waddr,
	output entry_t               mem_wdata,
	output logic                 mac_clear,
	output logic                 mac_valid,
	input  logic                 mac_busy,
	input  logic [TOT_AMT_W-1:0] tot_amount,
	input  logic [TOT_VAL_W-1:0] tot_value
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t             state_q, state_d;
	op_t                op_q, op_d;
	result_t            res_q, res_d;
	logic [CNT_W-1:0]   used_q, used_d;
	logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]   tgt_q, tgt_d;
	logic               val_s1, val_d;
	logic [ADDR_W-1:0]  idx_s1, idx_d;
	logic               key_ge, key_eq;

	assign key_ge = $signed(mem_rdata.key) >= $signed(op_q.ent.key);
	assign key_eq = mem_rdata.key == op_q.ent.key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			rd_idx_q <= '0;
			val_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			rd_idx_q <= rd_idx_d;
			val_s1   <= val_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		res_q  <= res_d;
		tgt_q  <= tgt_d;
		idx_s1 <= idx_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		res_d     = res_q;
		used_d    = used_q;
		rd_idx_d  = rd_idx_q;
		tgt_d     = tgt_q;
		val_d     = 1'b0;
		idx_d     = idx_s1;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_ren   = 1'b0;
		mem_raddr = rd_idx_q[ADDR_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		mac_clear = 1'b0;
		mac_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = in_op;
					res_d    = '0;
					rd_idx_d = '0;
					unique case (in_op.mode)
						MODE_INSERT: begin
							if (used_q == CNT_W'(CAPACITY)) begin
								res_d.status = ST_FULL;
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						MODE_LOOKUP, MODE_UPDATE, MODE_DELETE: begin
							state_d = S_SCAN;
						end
						MODE_STATS: begin
							mac_clear = 1'b1;
							state_d = S_STATS;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			S_SCAN: begin
				if (val_s1 && key_ge && key_eq) begin
					// key present at idx_s1
					res_d.position = POS_W'(idx_s1);
					unique case (op_q.mode)
						MODE_INSERT: begin
							res_d.status = ST_DUPLICATE;
							state_d = S_DONE;
						end
						MODE_LOOKUP: begin
							res_d.found_amount = mem_rdata.amount;
							res_d.found_price  = mem_rdata.price;
							state_d = S_DONE;
						end
						MODE_UPDATE: begin
							mem_we    = 1'b1;
							mem_waddr = idx_s1;
							mem_wdata = op_q.ent;
							state_d = S_DONE;
						end
						MODE_DELETE: begin
							rd_idx_d = CNT_W'(idx_s1) + 1'b1;
							state_d = S_SHIFT_DN;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end else if ((val_s1 && key_ge) || (!val_s1 && rd_idx_q >= used_q)) begin
					// key absent; insertion point is the first larger key or the end
					if (op_q.mode == MODE_INSERT) begin
						tgt_d    = val_s1 ? CNT_W'(idx_s1) : used_q;
						rd_idx_d = used_q;
						res_d.position = val_s1 ? POS_W'(idx_s1) : POS_W'(used_q);
						state_d = S_SHIFT_UP;
					end else begin
						res_d.status = ST_NOT_FOUND;
						state_d = S_DONE;
					end
				end else if (rd_idx_q < used_q) begin
					mem_ren  = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					val_d    = 1'b1;
					idx_d    = rd_idx_q[ADDR_W-1:0];
				end
			end

			S_SHIFT_UP: begin
				if (val_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(idx_s1 + 1'b1);
					mem_wdata = mem_rdata;
				end
				if (!val_s1 && rd_idx_q == tgt_q) begin
					mem_we    = 1'b1;
					mem_waddr = tgt_q[ADDR_W-1:0];
					mem_wdata = op_q.ent;
					used_d    = used_q + 1'b1;
					state_d   = S_DONE;
				end else if (rd_idx_q > tgt_q) begin
					mem_ren   = 1'b1;
					mem_raddr = ADDR_W'(rd_idx_q - 1'b1);
					rd_idx_d  = rd_idx_q - 1'b1;
					val_d     = 1'b1;
					idx_d     = ADDR_W'(rd_idx_q - 1'b1);
				end
			end

			S_SHIFT_DN: begin
				if (val_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(idx_s1 - 1'b1);
					mem_wdata = mem_rdata;
				end
				if (!val_s1 && rd_idx_q >= used_q) begin
					used_d  = used_q - 1'b1;
					state_d = S_DONE;
				end else if (rd_idx_q < used_q) begin
					mem_ren  = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					val_d    = 1'b1;
					idx_d    = rd_idx_q[ADDR_W-1:0];
				end
			end

			S_STATS: begin
				mac_valid = val_s1;
				if (!val_s1 && !mac_busy && rd_idx_q >= used_q) begin
					res_d.total_amount = tot_amount;
					res_d.total_value  = tot_value;
					state_d = S_DONE;
				end else if (rd_idx_q < used_q) begin
					mem_ren  = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					val_d    = 1'b1;
					idx_d    = rd_idx_q[ADDR_W-1:0];
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res = res_q;
		res.entry_count = COUNT_W'(used_q);
	end

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |->
			(used_q == CNT_W'($past(used_q) + 1'b1) ||
			 used_q == CNT_W'($past(used_q) - 1'b1)))
		else $error("entry count moved by more than one");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_ren |-> mem_waddr != mem_raddr)
		else $error("read and write of the same entry in one cycle");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted word left no operation in progress");
`endif

endmodule

// ===== rtl/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to CAPACITY entries sorted by ascending signed key, with insert,
// lookup, update, delete and statistics operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per operation. s_tuser carries the mode,
//   s_tdata the key, quantity and unit price in cents.
//   Output stream m_*: exactly one result word per input word, in order.
//   An operation walks the stored entries one per cycle through the single
//   read port of the entry memory. Lookup, update and failed searches stop
//   at the first key not below the target; insert then shifts the entries
//   from the insertion point up, delete shifts those above the match down,
//   and statistics read every entry. A full table or an unused mode answers
//   without a walk.
//   One operation is in progress at a time; s_tready is high while idle.
//   The result sits in an output register: the next word is taken while it
//   waits, but that operation holds its result until the register frees.
//   Reset clears the entry count and both streams; no memory clearing pass
//   is needed since only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int CAPACITY = SKT_CAPACITY
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // key[31:0], amount[15:0], price_cents[23:0]
	input  logic [2:0]   s_tuser,  // mode[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // status, position, found_amount, found_price,
	                               // entry_count, total_amount, total_value, pad
);

	localparam int ADDR_W = $clog2(CAPACITY);

	op_t                  in_op;
	result_t              res;
	logic                 res_valid, res_take;
	logic                 mem_ren, mem_we;
	logic [ADDR_W-1:0]    mem_raddr, mem_waddr;
	entry_t               mem_rdata, mem_wdata;
	logic                 mac_clear, mac_valid, mac_busy;
	logic [TOT_AMT_W-1:0] tot_amount;
	logic [TOT_VAL_W-1:0] tot_value;
	logic                 m_tvalid_q;
	logic [127:0]         m_tdata_q;

	always_comb begin
		in_op.mode       = s_tuser;
		in_op.ent.key    = s_tdata[31:0];
		in_op.ent.amount = s_tdata[47:32];
		in_op.ent.price  = s_tdata[71:48];
	end

	skt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (in_op),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_ren   (mem_ren),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mac_clear (mac_clear),
		.mac_valid (mac_valid),
		.mac_busy  (mac_busy),
		.tot_amount(tot_amount),
		.tot_value (tot_value)
	);

	skt_mem #(
		.CAPACITY(CAPACITY)
	) u_mem (
		.clk  (clk),
		.ren  (mem_ren),
		.raddr(mem_raddr),
		.rdata(mem_rdata),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata)
	);

	skt_mac #(
		.CAPACITY(CAPACITY)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (mac_clear),
		.valid     (mac_valid),
		.amount    (mem_rdata.amount),
		.price     (mem_rdata.price),
		.busy      (mac_busy),
		.tot_amount(tot_amount),
		.tot_value (tot_value)
	);

	// load the output register when empty or being drained
	assign res_take = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			m_tdata_q <= {1'b0, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
